// File: rtl/core/glmrs_pkg.sv
// Shared types, constants and the helper function of the grid local minimum core.
// Used by grid_local_minimum_risk_sum_core; depends on nothing else.
package glmrs_pkg;

  localparam int DIGIT_W = 4;
  localparam int CFG_W   = 8;
  localparam int POS_W   = 7;
  localparam int RISK_W  = 18;

  localparam logic [RISK_W-1:0] RISK_MAX = {RISK_W{1'b1}};

  // Configuration register indexes and their reset values.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 8'd128;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 8'd128;

  // Result queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // One decided cell as it leaves the block.
  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [DIGIT_W-1:0] value;
    logic               low;
    logic [RISK_W-1:0]  risk;
    logic               last;
    logic               done;
  } result_t;

  // One row buffer word: the row two above in the high half, the row above
  // in the low half.
  typedef struct packed {
    logic [DIGIT_W-1:0] older;
    logic [DIGIT_W-1:0] prev;
  } row_word_t;

  // Adds value plus one to the risk total and clamps at the top.
  function automatic logic [RISK_W-1:0] risk_add(input logic [RISK_W-1:0] acc,
                                                 input logic [DIGIT_W-1:0] v);
    logic [RISK_W:0] sum;
    sum = {1'b0, acc} + (RISK_W+1)'(v) + (RISK_W+1)'(1);
    if (sum > {1'b0, RISK_MAX}) begin
      return RISK_MAX;
    end
    return sum[RISK_W-1:0];
  endfunction

endpackage

// File: rtl/core/grid_local_minimum_risk_sum_core.sv
// Top level of the four-neighbour local minimum detector with risk total.
// Depends on glmrs_pkg (types, constants, risk adder) and glmrs_ram (row buffer).
//
// Usage: height digits of a grid enter on the input channel (in_valid,
// in_stall, height_digit) one request per cell in raster order. Each cell is
// decided once enough of its neighbours have been seen, and every decision
// leaves as one request on the output channel (out_valid, out_stall and the
// result fields). A cell is decided when the cell below it arrives; in the
// last row when its right neighbour arrives, and the final cell on its own.
// One input causes zero to three results, given in raster order of the cells.
// A request that is taken is registered together with its row buffer words in
// the decision stage, its results are then written into a four-entry result
// queue, and they are taken from the head of that queue.
// Throughput: one input per cycle while each input causes at most one result
// and the receiver does not stall; the output drains one result per cycle, so
// last-row inputs that cause two or three results are paced by the output side
// through the queue's free space. The row buffer has one write and two read ports.
// When the receiver stalls, the head of the queue holds still and the input
// keeps flowing until the queue cannot take the next input's results.
// Reset (rst, synchronous) restores grid_width and grid_height to 128, clears
// position, risk total and queue. Any configuration write restarts the frame.
// Row buffer contents are not cleared; each entry is written before it is used.
module grid_local_minimum_risk_sum_core #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [glmrs_pkg::DIGIT_W-1:0]      height_digit,
  // Output channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [glmrs_pkg::POS_W-1:0]        cell_x,
  output logic [glmrs_pkg::POS_W-1:0]        cell_y,
  output logic [glmrs_pkg::DIGIT_W-1:0]      cell_value,
  output logic                               is_low_point,
  output logic [glmrs_pkg::RISK_W-1:0]       risk_total,
  output logic                               last_of_run,
  output logic                               frame_done
);

  import glmrs_pkg::*;

  // Column counter holds values up to MAX_WIDTH, row counter up to MAX_HEIGHT.
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_GRID_WIDTH:  prdata = 32'(grid_width);
      REG_GRID_HEIGHT: prdata = 32'(grid_height);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RESET;
      grid_height <= GRID_HEIGHT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_GRID_WIDTH) begin
        grid_width <= pwdata[CFG_W-1:0];
      end else begin
        grid_height <= pwdata[CFG_W-1:0];
      end
    end
  end

  // Sizes in use: zero acts as one, anything above the maximum as the maximum.
  logic [CW-1:0] eff_w;
  logic [RW-1:0] eff_h;

  always_comb begin
    if (grid_width == '0) begin
      eff_w = CW'(1);
    end else if (int'(grid_width) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(grid_width);
    end
    if (grid_height == '0) begin
      eff_h = RW'(1);
    end else if (int'(grid_height) > MAX_HEIGHT) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(grid_height);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: position counters and the row buffer reads. The buffer is read
  // at the accepted cell's column and the column to its right.
  // ---------------------------------------------------------------------------
  logic          in_accept;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          at_last_col;
  logic          at_last_row;

  assign in_accept   = in_valid && !in_stall;
  assign at_last_col = (col + CW'(1)) == eff_w;
  assign at_last_row = (row + RW'(1)) == eff_h;

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      col <= '0;
      row <= '0;
    end else if (in_accept) begin
      if (at_last_col) begin
        col <= '0;
        row <= at_last_row ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  logic [AW-1:0] raddr0;
  logic [AW-1:0] raddr1;
  row_word_t     rdata0;
  row_word_t     rdata1;

  assign raddr0 = col[AW-1:0];
  assign raddr1 = AW'(col + CW'(1));

  // ---------------------------------------------------------------------------
  // Decision stage: the accepted cell with its row buffer words.
  // ---------------------------------------------------------------------------
  logic               s1_valid;
  logic               s1_adv;
  logic [DIGIT_W-1:0] s1_cur;
  logic [CW-1:0]      s1_x;
  logic [RW-1:0]      s1_y;
  logic               s1_has_up;
  logic               s1_has_up2;
  logic               s1_has_left;
  logic               s1_has_left2;
  logic               s1_has_right;
  logic               s1_last_row;
  logic               s1_last_col;
  // Forwarding of the row buffer write that lands on the same edge as a read.
  logic               fwd0;
  logic               fwd1;
  row_word_t          fwd_word;

  row_word_t          word_here;
  row_word_t          word_right;
  row_word_t          wr_word;
  logic [AW-1:0]      wr_addr;

  assign word_here  = fwd0 ? fwd_word : rdata0;
  assign word_right = fwd1 ? fwd_word : rdata1;
  assign wr_addr    = s1_x[AW-1:0];
  assign wr_word    = '{older: word_here.prev, prev: s1_cur};

  glmrs_ram #(
    .WIDTH ($bits(row_word_t)),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk    (clk),
    .we     (s1_adv),
    .waddr  (wr_addr),
    .wdata  (wr_word),
    .re     (in_accept),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cur       <= height_digit;
      s1_x         <= col;
      s1_y         <= row;
      s1_has_up    <= row != '0;
      s1_has_up2   <= row > RW'(1);
      s1_has_left  <= col != '0;
      s1_has_left2 <= col > CW'(1);
      s1_has_right <= !at_last_col;
      s1_last_row  <= at_last_row;
      s1_last_col  <= at_last_col;
      fwd0         <= s1_adv && (wr_addr == raddr0);
      fwd1         <= s1_adv && (wr_addr == raddr1);
      fwd_word     <= wr_word;
    end
  end

  // Values carried from one cell to the next within a row: the two previous
  // inputs and the previous cell's upper neighbour, which is the row buffer's
  // prev entry one column to the left.
  logic [DIGIT_W-1:0] left_cell;
  logic [DIGIT_W-1:0] second_left_cell;
  logic [DIGIT_W-1:0] last_mid;
  logic [RISK_W-1:0]  risk_accumulator;

  // Three candidate decisions of the current cell, in raster order.
  logic               up_valid;
  logic               left_valid;
  logic               self_valid;
  logic               up_low;
  logic               left_low;
  logic               self_low;
  logic [DIGIT_W-1:0] mid;
  logic [RISK_W-1:0]  risk_up;
  logic [RISK_W-1:0]  risk_left;
  logic [RISK_W-1:0]  risk_self;
  result_t            res [3];
  logic               res_valid [3];
  logic [Q_AW-1:0]    res_off [3];
  logic [Q_CW-1:0]    n_res;

  assign mid = word_here.prev;

  always_comb begin
    up_valid   = s1_has_up;
    left_valid = s1_last_row && s1_has_left;
    self_valid = s1_last_row && s1_last_col;

    // Cell above: its neighbours are the current input below, the cell to its
    // left and right in the row above, and the cell two rows up.
    up_low = (s1_cur > mid)
          && (!s1_has_left  || (last_mid > mid))
          && (!s1_has_up2   || (word_here.older > mid))
          && (!s1_has_right || (word_right.prev > mid));

    // Cell to the left in the last row: no cell below it.
    left_low = (s1_cur > left_cell)
            && (!s1_has_left2 || (second_left_cell > left_cell))
            && (!s1_has_up    || (last_mid > left_cell));

    // Final cell of the grid: only left and upper neighbours exist.
    self_low = (!s1_has_left || (left_cell > s1_cur))
            && (!s1_has_up   || (mid > s1_cur));

    risk_up   = (up_valid && up_low) ? risk_add(risk_accumulator, mid) : risk_accumulator;
    risk_left = (left_valid && left_low) ? risk_add(risk_up, left_cell) : risk_up;
    risk_self = (self_valid && self_low) ? risk_add(risk_left, s1_cur) : risk_left;

    res[0] = '{x: POS_W'(s1_x), y: POS_W'(s1_y - RW'(1)), value: mid, low: up_low,
               risk: risk_up, last: !left_valid && !self_valid, done: 1'b0};
    res[1] = '{x: POS_W'(s1_x - CW'(1)), y: POS_W'(s1_y), value: left_cell,
               low: left_low, risk: risk_left, last: !self_valid, done: 1'b0};
    res[2] = '{x: POS_W'(s1_x), y: POS_W'(s1_y), value: s1_cur, low: self_low,
               risk: risk_self, last: 1'b1, done: 1'b1};

    res_valid[0] = up_valid;
    res_valid[1] = left_valid;
    res_valid[2] = self_valid;

    res_off[0] = '0;
    res_off[1] = Q_AW'(up_valid);
    res_off[2] = Q_AW'(up_valid) + Q_AW'(left_valid);

    n_res = Q_CW'(up_valid) + Q_CW'(left_valid) + Q_CW'(self_valid);
  end

  // ---------------------------------------------------------------------------
  // Result queue. The decision stage moves on only when the queue has room for
  // all of its results; the free space is taken before this cycle's pop so
  // that the output stall never reaches the input stall in the same cycle.
  // ---------------------------------------------------------------------------
  result_t         queue [Q_DEPTH];
  logic [Q_AW-1:0] q_head;
  logic [Q_AW-1:0] q_tail;
  logic [Q_CW-1:0] q_count;
  logic            q_pop;
  logic [Q_CW-1:0] q_push;

  assign s1_adv = s1_valid && ((Q_CW'(Q_DEPTH) - q_count) >= n_res);
  assign q_pop  = out_valid && !out_stall;
  assign q_push = s1_adv ? n_res : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      q_head  <= q_head + Q_AW'(q_pop);
      q_tail  <= q_tail + Q_AW'(q_push);
      q_count <= q_count + q_push - Q_CW'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        if (res_valid[i]) begin
          queue[q_tail + res_off[i]] <= res[i];
        end
      end
    end
  end

  // Carried state moves forward with each decided input. The risk total starts
  // over after the final cell of a grid and on any configuration write.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      left_cell        <= '0;
      second_left_cell <= '0;
      last_mid         <= '0;
      risk_accumulator <= '0;
    end else if (s1_adv) begin
      left_cell        <= s1_cur;
      second_left_cell <= left_cell;
      last_mid         <= mid;
      risk_accumulator <= self_valid ? '0 : risk_self;
    end
  end

  assign out_valid    = q_count != '0;
  assign cell_x       = queue[q_head].x;
  assign cell_y       = queue[q_head].y;
  assign cell_value   = queue[q_head].value;
  assign is_low_point = queue[q_head].low;
  assign risk_total   = queue[q_head].risk;
  assign last_of_run  = queue[q_head].last;
  assign frame_done   = queue[q_head].done;

endmodule

// File: rtl/core/glmrs_ram.sv
// Generic RAM: one write port, two read ports with a shared
// read enable and registered read data. No dependencies.
module glmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr0,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr1,
  output logic [WIDTH-1:0]                       rdata0,
  output logic [WIDTH-1:0]                       rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule
